>>> rtl/tcprc_pkg.sv
// Shared types and constants of the TCP receive flow coalescer.
package tcprc_pkg;

	localparam int FLOWS = 16;
	localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int TIME_W = 48;
	localparam logic [7:0] NON_ACK_FLAGS = 8'hef;
	localparam logic [15:0] MAX_LEN_RST = 16'hffff;
	localparam logic [15:0] AGE_RST = 16'd100;
	localparam logic CFG_MAX_LEN = 1'b0;
	localparam logic CFG_AGE = 1'b1;

	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_ATTACH = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_PASS,
		CMD_PKT
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE,
		ST_SCAN,
		ST_EVICT,
		ST_EMIT,
		ST_TICK,
		ST_TICK_EMIT
	} state_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [95:0] tuple;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0] flags;
		logic [15:0] plen;
		logic [15:0] flen;
		logic [15:0] tag;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic [15:0] tag;
		logic [5:0] slot;
		logic [15:0] len;
		logic [7:0] flags;
		logic [15:0] seg;
		logic last;
	} result_t;

endpackage

>>> rtl/tcp_receive_flow_coalescer.sv
// Top level of the TCP receive flow coalescer.
// An ineligible packet goes from the front queue via idle straight to emit;
// an eligible one passes lookup and decide first, plus a scan and an evict
// step when the oldest flow is evicted. A tick marks the aged flows, then
// flushes them one at a time. The engine takes a new transaction only in idle.
// Reset clears all flows, the microsecond counter and the queues, and restores
// the configuration defaults.
module tcp_receive_flow_coalescer import tcprc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_addr,
	input  logic [15:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// ip_src, ip_dst, tcp_sport, tcp_dport, seq_num, ack_num, tcp_flag_bits,
	// payload_len, frame_len, packet_tag
	input  logic [215:0] s_axis_tdata,
	// mode, eligible
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_tag, slot_index, merged_len, merged_flags, largest_segment, zero pad
	output logic [63:0] m_axis_tdata,
	// result_kind
	output logic [1:0] m_axis_tuser,
	output logic m_axis_tlast
);

	logic [15:0] max_len_q, age_q;
	logic cmd_valid, cmd_pop, out_free, push;
	cmd_t cmd;
	result_t push_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			age_q <= AGE_RST;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_MAX_LEN) max_len_q <= cfg_data;
			if (cfg_addr == CFG_AGE) age_q <= cfg_data;
		end
	end

	tcprc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	tcprc_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.max_merged_len(max_len_q), .age_limit_us(age_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.out_free(out_free), .push(push), .push_res(push_res)
	);

	tcprc_out u_out (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_res(push_res), .out_free(out_free),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

>>> rtl/tcprc_front.sv
// Front end: accept transactions, classify them and queue them for the engine.
module tcprc_front import tcprc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// ip_src, ip_dst, tcp_sport, tcp_dport, seq_num, ack_num, tcp_flag_bits,
	// payload_len, frame_len, packet_tag
	input  logic [215:0] s_axis_tdata,
	// mode, eligible
	input  logic [1:0] s_axis_tuser,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	cmd_t fifo_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t in_cmd;
	logic push;

	always_comb begin
		in_cmd.tuple = {s_axis_tdata[31:0], s_axis_tdata[63:32],
			s_axis_tdata[79:64], s_axis_tdata[95:80]};
		in_cmd.seq = s_axis_tdata[127:96];
		in_cmd.ack = s_axis_tdata[159:128];
		in_cmd.flags = s_axis_tdata[167:160];
		in_cmd.plen = s_axis_tdata[183:168];
		in_cmd.flen = s_axis_tdata[199:184];
		in_cmd.tag = s_axis_tdata[215:200];
		if (s_axis_tuser[0]) begin
			in_cmd.kind = CMD_TICK;
		end else if (!s_axis_tuser[1]) begin
			in_cmd.kind = CMD_PASS;
		end else begin
			in_cmd.kind = CMD_PKT;
		end
	end

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push = s_axis_tvalid && s_axis_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			if (push && !cmd_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && cmd_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_cmd;
	end

endmodule

>>> rtl/tcprc_engine.sv
// Back end: flow table, merge decisions, eviction and ageing.
module tcprc_engine import tcprc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [15:0] max_merged_len,
	input  logic [15:0] age_limit_us,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic out_free,
	output logic push,
	output result_t push_res
);

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [FLOWS-1:0] valid_q, mask_q, aged;
	logic [95:0] tup_q [FLOWS];
	logic [31:0] nseq_q [FLOWS];
	logic [31:0] ack_q [FLOWS];
	logic [7:0] flg_q [FLOWS];
	logic [15:0] len_q [FLOWS];
	logic [15:0] seg_q [FLOWS];
	logic [15:0] tag_q [FLOWS];
	logic [TIME_W-1:0] start_q [FLOWS];
	logic [TIME_W-1:0] now_q;
	logic hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, scan_q, best_q, emit_i_q;
	logic [IDX_W-1:0] hit_idx, free_idx, pick;
	logic hit_any, free_any, n_q;
	result_t res_q [2];

	logic [IDX_W-1:0] hs;
	logic [16:0] sum;
	logic ovf, mism;
	logic [7:0] new_flags;
	logic [15:0] new_seg;
	logic dec_flush;
	logic [FLOWS-1:0] pick_oh;

	function automatic result_t mk_res(kind_t k, logic [15:0] tg, logic [IDX_W-1:0] s,
		logic [15:0] l, logic [7:0] f, logic [15:0] sg, logic lst);
		result_t r;
		r.kind = k;
		r.tag = tg;
		r.slot = 6'(s);
		r.len = l;
		r.flags = f;
		r.seg = sg;
		r.last = lst;
		return r;
	endfunction

	always_comb begin
		hit_any = 1'b0;
		free_any = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = FLOWS - 1; i >= 0; i--) begin
			if (valid_q[i] && tup_q[i] == cmd_q.tuple) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
		for (int i = 0; i < FLOWS; i++) begin
			aged[i] = valid_q[i] && ((now_q - start_q[i]) > {32'd0, age_limit_us});
		end
		pick = '0;
		for (int i = FLOWS - 1; i >= 0; i--) begin
			if (mask_q[i]) pick = IDX_W'(i);
		end
		pick_oh = '0;
		pick_oh[pick] = 1'b1;
	end

	assign hs = hit_idx_q;
	assign sum = {1'b0, len_q[hs]} + {1'b0, cmd_q.plen};
	assign ovf = sum > {1'b0, max_merged_len};
	assign mism = (nseq_q[hs] != cmd_q.seq) || (ack_q[hs] != cmd_q.ack);
	assign new_flags = flg_q[hs] | cmd_q.flags;
	assign new_seg = (cmd_q.plen > seg_q[hs]) ? cmd_q.plen : seg_q[hs];
	assign dec_flush = (new_flags & NON_ACK_FLAGS) != 8'd0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_TICK: state_d = ST_TICK;
						CMD_PASS: state_d = ST_EMIT;
						default: state_d = ST_LOOKUP;
					endcase
				end
			end
			ST_LOOKUP: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (hit_q) begin
					state_d = (!mism && ovf) ? ST_EMIT : ST_EMIT;
				end else if ((cmd_q.flags & NON_ACK_FLAGS) != 8'd0) begin
					state_d = ST_EMIT;
				end else if (free_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = (FLOWS > 1) ? ST_SCAN : ST_EVICT;
				end
			end
			ST_SCAN: if (scan_q == IDX_W'(FLOWS - 1)) state_d = ST_EVICT;
			ST_EVICT: state_d = ST_EMIT;
			ST_EMIT: if (out_free && emit_i_q == IDX_W'(n_q)) state_d = ST_IDLE;
			ST_TICK: state_d = ST_TICK_EMIT;
			ST_TICK_EMIT: begin
				if (mask_q == '0) state_d = ST_IDLE;
				else if (out_free && (mask_q & ~pick_oh) == '0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		push = 1'b0;
		push_res = res_q[emit_i_q[0]];
		unique case (state_q)
			ST_IDLE: cmd_pop = cmd_valid;
			ST_EMIT: push = out_free;
			ST_TICK_EMIT: begin
				push = out_free && (mask_q != '0);
				push_res = mk_res(KIND_FLUSH, tag_q[pick], pick, len_q[pick], flg_q[pick],
					seg_q[pick], (mask_q & ~pick_oh) == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			now_q <= '0;
			mask_q <= '0;
			emit_i_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					emit_i_q <= '0;
					if (cmd_valid && cmd.kind == CMD_TICK) now_q <= now_q + 1'b1;
				end
				ST_DECIDE: begin
					if (hit_q) begin
						if (mism || (!ovf && dec_flush)) valid_q[hs] <= 1'b0;
					end else if ((cmd_q.flags & NON_ACK_FLAGS) == 8'd0 && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				ST_EMIT: if (out_free) emit_i_q <= emit_i_q + 1'b1;
				ST_TICK: mask_q <= aged;
				ST_TICK_EMIT: begin
					if (out_free && mask_q != '0) begin
						mask_q <= mask_q & ~pick_oh;
						valid_q <= valid_q & ~pick_oh;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd;
				n_q <= 1'b0;
				res_q[0] <= mk_res(KIND_PASS, cmd.tag, '0, '0, '0, '0, 1'b1);
			end
			ST_LOOKUP: begin
				hit_q <= hit_any;
				hit_idx_q <= hit_idx;
				free_q <= free_any;
				free_idx_q <= free_idx;
				scan_q <= IDX_W'(1);
				best_q <= '0;
			end
			ST_DECIDE: begin
				if (hit_q) begin
					if (mism) begin
						n_q <= 1'b1;
						res_q[0] <= mk_res(KIND_FLUSH, tag_q[hs], hs, len_q[hs], flg_q[hs],
							seg_q[hs], 1'b0);
						res_q[1] <= mk_res(KIND_PASS, cmd_q.tag, '0, '0, '0, '0, 1'b1);
					end else if (ovf) begin
						res_q[0] <= mk_res(KIND_FLUSH, tag_q[hs], hs, len_q[hs], flg_q[hs],
							seg_q[hs], 1'b1);
						tup_q[hs] <= cmd_q.tuple;
						nseq_q[hs] <= cmd_q.seq + {16'd0, cmd_q.plen};
						ack_q[hs] <= cmd_q.ack;
						flg_q[hs] <= cmd_q.flags;
						len_q[hs] <= cmd_q.flen;
						seg_q[hs] <= '0;
						tag_q[hs] <= cmd_q.tag;
						start_q[hs] <= now_q;
					end else begin
						n_q <= dec_flush;
						res_q[0] <= mk_res(KIND_ATTACH, cmd_q.tag, hs, '0, '0, '0, !dec_flush);
						res_q[1] <= mk_res(KIND_FLUSH, tag_q[hs], hs, sum[15:0], new_flags,
							new_seg, 1'b1);
						flg_q[hs] <= new_flags;
						len_q[hs] <= sum[15:0];
						seg_q[hs] <= new_seg;
						if (!dec_flush) nseq_q[hs] <= cmd_q.seq + {16'd0, cmd_q.plen};
					end
				end else if ((cmd_q.flags & NON_ACK_FLAGS) == 8'd0 && free_q) begin
					tup_q[free_idx_q] <= cmd_q.tuple;
					nseq_q[free_idx_q] <= cmd_q.seq + {16'd0, cmd_q.plen};
					ack_q[free_idx_q] <= cmd_q.ack;
					flg_q[free_idx_q] <= cmd_q.flags;
					len_q[free_idx_q] <= cmd_q.flen;
					seg_q[free_idx_q] <= '0;
					tag_q[free_idx_q] <= cmd_q.tag;
					start_q[free_idx_q] <= now_q;
				end
			end
			ST_SCAN: begin
				if (start_q[scan_q] < start_q[best_q]) best_q <= scan_q;
				scan_q <= scan_q + 1'b1;
			end
			ST_EVICT: begin
				res_q[0] <= mk_res(KIND_FLUSH, tag_q[best_q], best_q, len_q[best_q],
					flg_q[best_q], seg_q[best_q], 1'b1);
				tup_q[best_q] <= cmd_q.tuple;
				nseq_q[best_q] <= cmd_q.seq + {16'd0, cmd_q.plen};
				ack_q[best_q] <= cmd_q.ack;
				flg_q[best_q] <= cmd_q.flags;
				len_q[best_q] <= cmd_q.flen;
				seg_q[best_q] <= '0;
				tag_q[best_q] <= cmd_q.tag;
				start_q[best_q] <= now_q;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/tcprc_out.sv
// Output register holding one result transaction.
module tcprc_out import tcprc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  result_t push_res,
	output logic out_free,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_tag, slot_index, merged_len, merged_flags, largest_segment, zero pad
	output logic [63:0] m_axis_tdata,
	// result_kind
	output logic [1:0] m_axis_tuser,
	output logic m_axis_tlast
);

	result_t res_q;
	logic vld_q;

	assign out_free = !vld_q || m_axis_tready;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {2'b00, res_q.seg, res_q.flags, res_q.len, res_q.slot, res_q.tag};
	assign m_axis_tuser = res_q.kind;
	assign m_axis_tlast = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) res_q <= push_res;
	end

endmodule
